/* design/lvavg_pkg.sv */
// ----------------------------------------------------------------------------
// lvavg_pkg: shared types and constants of the landing velocity average unit
// Widths, transfer structs, sequencer states, register indexes and divider
// handshake structs.
// ----------------------------------------------------------------------------
package lvavg_pkg;

    // Averaging ring
    localparam int AVG_DEPTH = 10;
    localparam int POS_W     = $clog2(AVG_DEPTH);

    // Field widths
    localparam int ALT_W   = 24;
    localparam int SPD_W   = 24;
    localparam int TIME_W  = 32;
    localparam int DT_W    = 16;
    localparam int CMD_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W   = 8;

    // Speed arithmetic
    localparam int DIFF_W  = ALT_W + 1;
    localparam int MAG_W   = ALT_W;
    localparam int SCALE   = 1000;
    localparam int SCALE_W = 10;
    localparam int DVD_W   = MAG_W + SCALE_W;
    localparam int DVS_W   = DT_W;
    localparam int DCNT_W  = $clog2(DVD_W);
    localparam int SUM_W   = SPD_W + $clog2(AVG_DEPTH);

    // Average by reciprocal multiplication: floor(x * AVG_RECIP >> AVG_SHIFT)
    // equals floor(x / AVG_DEPTH) for every sum magnitude the ring can reach
    localparam int AVG_SHIFT = SUM_W - 1 + POS_W;
    localparam int RCP_W     = SUM_W;
    localparam int PROD_W    = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] AVG_RECIP =
        RCP_W'(((longint'(1) << AVG_SHIFT) + AVG_DEPTH - 1) / AVG_DEPTH);

    localparam logic [SPD_W-1:0] SPD_MAX = {1'b0, {(SPD_W-1){1'b1}}};
    localparam logic [SPD_W-1:0] SPD_MIN = {1'b1, {(SPD_W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_TOP = {CNT_W{1'b1}};

    // Register reset values
    localparam logic [CFG_W-1:0] WIND_TIME_RST   = 16'd3000;
    localparam logic [CFG_W-1:0] SPEED_LIMIT_RST = 16'd100;
    localparam logic [CMD_W-1:0] SERVO_A_RST     = 8'd0;
    localparam logic [CMD_W-1:0] SERVO_B_RST     = 8'd180;
    localparam logic [CMD_W-1:0] SERVO_C_RST     = 8'd90;
    localparam logic [CMD_W-1:0] CAMERA_RST      = 8'd0;
    localparam logic [CMD_W-1:0] DEBOUNCE_RST    = 8'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIND_TIME   = 3'd0,
        CFG_SPEED_LIMIT = 3'd1,
        CFG_SERVO_A     = 3'd2,
        CFG_SERVO_B     = 3'd3,
        CFG_SERVO_C     = 3'd4,
        CFG_CAMERA      = 3'd5,
        CFG_DEBOUNCE    = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ABS,
        S_MUL,
        S_DIV1,
        S_SAT,
        S_SUM,
        S_ABS2,
        S_RECIP,
        S_CMP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                    enter_state;
        logic [TIME_W-1:0]       now_ms;
        logic signed [ALT_W-1:0] altitude_cm;
        logic [DT_W-1:0]         delta_ms;
    } t_in;

    typedef struct packed {
        logic [CMD_W-1:0]        para_servo_a_cmd;
        logic [CMD_W-1:0]        para_servo_b_cmd;
        logic [CMD_W-1:0]        camera_servo_cmd;
        logic signed [SPD_W-1:0] average_speed;
        logic                    landed_flag;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* design/landing_detector_velocity_average_unit.sv */
// ----------------------------------------------------------------------------
// landing_detector_velocity_average_unit: landing detector with speed average
// Vertical speed from altitude change, ten-sample running average, debounced
// landed flag and parachute/camera servo commands, one result per tick.
// ----------------------------------------------------------------------------
// Flow: each item steps through S_ABS, S_MUL, the divider wait S_DIV1, S_SAT,
//   S_SUM, S_ABS2, S_RECIP, S_CMP and S_OUT; a zero delta_ms skips the division.
//   No new item is taken until the last one leaves S_OUT. A result that still
//   waits unaccepted in the output register holds the next item in S_OUT.
// The next item is taken while a finished result still waits in the output
//   register.
// Reset (synchronous, active low) loads the register defaults and clears the
//   ring, running sum, previous altitude, start time and debounce count.
module landing_detector_velocity_average_unit
    import lvavg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in                  i_data,
    // output channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out                 o_data,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_wind_time;
    logic [CFG_W-1:0] r_speed_limit;
    logic [CMD_W-1:0] r_servo_a;
    logic [CMD_W-1:0] r_servo_b;
    logic [CMD_W-1:0] r_servo_c;
    logic [CMD_W-1:0] r_camera;
    logic [CMD_W-1:0] r_debounce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind_time   <= WIND_TIME_RST;
            r_speed_limit <= SPEED_LIMIT_RST;
            r_servo_a     <= SERVO_A_RST;
            r_servo_b     <= SERVO_B_RST;
            r_servo_c     <= SERVO_C_RST;
            r_camera      <= CAMERA_RST;
            r_debounce    <= DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            // Unknown indexes drop the write
            case (i_cfg_idx)
                CFG_WIND_TIME:   r_wind_time   <= i_cfg_data;
                CFG_SPEED_LIMIT: r_speed_limit <= i_cfg_data;
                CFG_SERVO_A:     r_servo_a     <= i_cfg_data[CMD_W-1:0];
                CFG_SERVO_B:     r_servo_b     <= i_cfg_data[CMD_W-1:0];
                CFG_SERVO_C:     r_servo_c     <= i_cfg_data[CMD_W-1:0];
                CFG_CAMERA:      r_camera      <= i_cfg_data[CMD_W-1:0];
                CFG_DEBOUNCE:    r_debounce    <= i_cfg_data[CMD_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state   r_state;
    t_state   n_state;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    logic     w_in_xfer;
    logic     w_out_free;

    // Architectural state
    logic signed [ALT_W-1:0]  r_prev_alt;
    logic [TIME_W-1:0]        r_start_ms;
    logic signed [SPD_W-1:0]  r_ring [AVG_DEPTH];
    logic [POS_W-1:0]         r_pos;
    logic signed [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]         r_qual_cnt;

    // Per-item working registers
    logic                     r_unwind;
    logic [DT_W-1:0]          r_dt;
    logic signed [DIFF_W-1:0] r_diff;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;
    logic signed [SPD_W-1:0]  r_speed;
    logic signed [SUM_W-1:0]  r_part;
    logic                     r_sneg;
    logic [SUM_W-1:0]         r_smag;
    logic [SPD_W-1:0]         r_avg_mag;
    logic signed [SPD_W-1:0]  r_avg;
    logic                     r_qual;

    // Output register
    logic                     r_o_valid;
    t_out                     r_o_data;

    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and divider requests
    logic [DVD_W-1:0] w_prod;
    logic [SUM_W-1:0] w_sum_mag;

    // Constant scale of the altitude change; registered by the divider load
    assign w_prod    = DVD_W'(r_mag) * DVD_W'(SCALE);
    assign w_sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_comb begin
        n_state            = r_state;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_prod;
        w_div_req.divisor  = r_dt;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                // A zero interval saturates without a division
                if (r_dt == '0) begin
                    n_state = S_SAT;
                end else begin
                    w_div_req.start = 1'b1;
                    n_state         = S_DIV1;
                end
            end
            S_DIV1: begin
                if (w_div_rsp.done) begin
                    n_state = S_SAT;
                end
            end
            S_SAT: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                n_state = S_ABS2;
            end
            S_ABS2: begin
                n_state = S_RECIP;
            end
            S_RECIP: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    lvavg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]        w_start_next;
    logic [TIME_W-1:0]        w_elapsed;
    logic signed [DIFF_W-1:0] w_diff;
    logic [DVD_W-1:0]         w_quo;
    logic signed [SPD_W-1:0]  w_old;
    logic [CNT_W-1:0]         w_cnt_next;
    logic [PROD_W-1:0]        w_avg_prod;

    // Entry tick captures the start time first, so elapsed is zero
    assign w_start_next = i_data.enter_state ? i_data.now_ms : r_start_ms;
    assign w_elapsed    = i_data.now_ms - w_start_next;
    assign w_diff       = {i_data.altitude_cm[ALT_W-1], i_data.altitude_cm}
                        - {r_prev_alt[ALT_W-1], r_prev_alt};
    assign w_quo        = w_div_rsp.quotient;
    assign w_old        = r_ring[r_pos];
    assign w_cnt_next   = !r_qual ? '0
                        : (r_qual_cnt == CNT_TOP) ? r_qual_cnt : r_qual_cnt + 1'b1;
    // Sum magnitude over the ring depth by multiplying with the reciprocal
    assign w_avg_prod   = PROD_W'(r_smag) * PROD_W'(AVG_RECIP);

    // Architectural state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_alt <= '0;
            r_start_ms <= '0;
            r_pos      <= '0;
            r_sum      <= '0;
            r_qual_cnt <= '0;
            for (int k = 0; k < AVG_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            if (w_in_xfer) begin
                r_prev_alt <= i_data.altitude_cm;
                r_start_ms <= w_start_next;
            end
            if (r_state == S_SUM) begin
                // Replace the oldest sample and advance the ring
                r_sum         <= r_part + {{(SUM_W-SPD_W){r_speed[SPD_W-1]}}, r_speed};
                r_ring[r_pos] <= r_speed;
                r_pos         <= (r_pos == POS_W'(AVG_DEPTH - 1)) ? '0 : r_pos + 1'b1;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_qual_cnt <= w_cnt_next;
            end
        end
    end

    // Per-item working registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_unwind <= (w_elapsed < {{(TIME_W-CFG_W){1'b0}}, r_wind_time});
            r_dt     <= i_data.delta_ms;
            r_diff   <= w_diff;
        end
        if (r_state == S_ABS) begin
            r_neg <= r_diff[DIFF_W-1];
            r_mag <= r_diff[DIFF_W-1] ? MAG_W'(-r_diff) : MAG_W'(r_diff);
        end
        if (r_state == S_SAT) begin
            if (r_dt == '0) begin
                r_speed <= r_neg ? SPD_MIN : SPD_MAX;
            end else if (r_neg) begin
                r_speed <= (w_quo >= DVD_W'(SPD_MIN)) ? SPD_MIN : SPD_W'(-w_quo);
            end else begin
                r_speed <= (w_quo > DVD_W'(SPD_MAX)) ? SPD_MAX : SPD_W'(w_quo);
            end
            r_part <= r_sum - {{(SUM_W-SPD_W){w_old[SPD_W-1]}}, w_old};
        end
        if (r_state == S_ABS2) begin
            r_sneg <= r_sum[SUM_W-1];
            r_smag <= w_sum_mag;
        end
        if (r_state == S_RECIP) begin
            r_avg_mag <= w_avg_prod[AVG_SHIFT +: SPD_W];
        end
        if (r_state == S_CMP) begin
            // Average truncates toward zero: divide the magnitude, restore the sign
            r_avg  <= r_sneg ? SPD_W'(-r_avg_mag) : SPD_W'(r_avg_mag);
            r_qual <= (r_avg_mag < {{(SPD_W-CFG_W){1'b0}}, r_speed_limit});
        end
    end

    // Output register: a result waits here while the next item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_o_data.para_servo_a_cmd <= r_unwind ? r_servo_a : r_servo_c;
            r_o_data.para_servo_b_cmd <= r_unwind ? r_servo_b : r_servo_c;
            r_o_data.camera_servo_cmd <= r_camera;
            r_o_data.average_speed    <= r_avg;
            r_o_data.landed_flag      <= (w_cnt_next >= r_debounce);
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_div_rsp.busy)
        else $error("divider still busy while the unit takes a new item");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV1))
        else $error("divider result arrived outside the wait state");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(AVG_DEPTH - 1))
        else $error("ring position past the last entry");

    a_one_result_per_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |=> (r_o_valid && r_state == S_IDLE))
        else $error("result not loaded when the item finished");

endmodule

/* design/lvavg_div.sv */
// ----------------------------------------------------------------------------
// lvavg_div: restoring divider
// Unsigned, one quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module lvavg_div
    import lvavg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVD_W-1:0]  r_quo;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W:0]    w_sub;
    logic              w_ge;

    // Shift in the next dividend bit and try the subtraction
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_sub   = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a preceding busy pass");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the landing detector velocity average unit
// Streams flight-loop ticks through the valid/ready input channel, predicts
// every result with a cycle-free model of the speed ring, debouncer and servo
// logic, and checks each output transfer field by field. Register settings
// change between phases while the unit is idle, and in some phases the input
// and output channels idle at random rates.
// ----------------------------------------------------------------------------
module tb_top;
    import lvavg_pkg::*;

    // Index with no register behind it; the unit must drop writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

    localparam longint SPEED_CEIL  = (longint'(1) << (SPD_W - 1)) - 1;
    localparam longint SPEED_FLOOR = -(longint'(1) << (SPD_W - 1));
    localparam logic signed [ALT_W-1:0] ALT_TOP    = {1'b0, {(ALT_W-1){1'b1}}};
    localparam logic signed [ALT_W-1:0] ALT_BOTTOM = {1'b1, {(ALT_W-1){1'b0}}};
    localparam logic [DT_W-1:0] DT_TOP = {DT_W{1'b1}};

    // Drain bound and settle time after the last result
    localparam int DRAIN_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 100;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_valid    = 1'b0;
    logic                 o_ready;
    t_in                  i_data     = '0;
    logic                 o_valid;
    logic                 i_ready    = 1'b0;
    t_out                 o_data;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    landing_detector_velocity_average_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor state: register mirror plus the unit's speed history
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0]        cfg_wind;
    logic [CFG_W-1:0]        cfg_limit;
    logic [CMD_W-1:0]        cfg_pos_a;
    logic [CMD_W-1:0]        cfg_pos_b;
    logic [CMD_W-1:0]        cfg_pos_c;
    logic [CMD_W-1:0]        cfg_cam;
    logic [CNT_W-1:0]        cfg_debounce;

    logic signed [ALT_W-1:0] prev_alt;
    logic signed [SPD_W-1:0] speed_hist [AVG_DEPTH];
    int                      hist_pos;
    logic signed [SUM_W-1:0] speed_sum;
    logic [TIME_W-1:0]       start_time;
    int                      hold_count;

    // Stimulus and scoreboard bookkeeping
    t_in  pending_ticks[$];
    t_out expected_reports[$];
    int   ticks_issued   = 0;
    int   reports_seen   = 0;
    int   landed_seen    = 0;
    int   zero_dt_ticks  = 0;
    int   settings_used  = 1;
    int   error_count    = 0;
    int   send_idle_pct  = 0;
    int   stall_pct      = 0;

    // Flight generator state
    logic [TIME_W-1:0] fl_time;
    int                fl_alt;

    function automatic void reset_predictor();
        cfg_wind     = WIND_TIME_RST;
        cfg_limit    = SPEED_LIMIT_RST;
        cfg_pos_a    = SERVO_A_RST;
        cfg_pos_b    = SERVO_B_RST;
        cfg_pos_c    = SERVO_C_RST;
        cfg_cam      = CAMERA_RST;
        cfg_debounce = DEBOUNCE_RST;
        prev_alt     = '0;
        foreach (speed_hist[k]) speed_hist[k] = '0;
        hist_pos     = 0;
        speed_sum    = '0;
        start_time   = '0;
        hold_count   = 0;
    endfunction

    function automatic void track_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            CFG_WIND_TIME:   cfg_wind     = value;
            CFG_SPEED_LIMIT: cfg_limit    = value;
            CFG_SERVO_A:     cfg_pos_a    = value[CMD_W-1:0];
            CFG_SERVO_B:     cfg_pos_b    = value[CMD_W-1:0];
            CFG_SERVO_C:     cfg_pos_c    = value[CMD_W-1:0];
            CFG_CAMERA:      cfg_cam      = value[CMD_W-1:0];
            CFG_DEBOUNCE:    cfg_debounce = value[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    // Expected result of one tick; advances the predictor state
    function automatic t_out predict_landing(t_in tick);
        t_out              res;
        logic [TIME_W-1:0] elapsed;
        longint            diff;
        longint            spd;
        longint            avg;
        longint            mag;

        // Capture the start time first so an entry tick sees zero elapsed
        if (tick.enter_state) start_time = tick.now_ms;
        elapsed = tick.now_ms - start_time;
        if (elapsed < TIME_W'(cfg_wind)) begin
            res.para_servo_a_cmd = cfg_pos_a;
            res.para_servo_b_cmd = cfg_pos_b;
        end else begin
            res.para_servo_a_cmd = cfg_pos_c;
            res.para_servo_b_cmd = cfg_pos_c;
        end
        res.camera_servo_cmd = cfg_cam;

        // Vertical speed, truncated toward zero and clipped to the speed range
        diff = longint'(tick.altitude_cm) - longint'(prev_alt);
        if (tick.delta_ms == '0) begin
            spd = (diff < 0) ? SPEED_FLOOR : SPEED_CEIL;
        end else begin
            spd = (diff * SCALE) / longint'(tick.delta_ms);
            if (spd > SPEED_CEIL) spd = SPEED_CEIL;
            if (spd < SPEED_FLOOR) spd = SPEED_FLOOR;
        end
        prev_alt = tick.altitude_cm;

        // Replace the oldest ring entry and keep the running sum in step
        speed_sum = speed_sum - speed_hist[hist_pos] + SPD_W'(spd);
        speed_hist[hist_pos] = SPD_W'(spd);
        hist_pos = (hist_pos == AVG_DEPTH - 1) ? 0 : hist_pos + 1;

        avg = longint'(speed_sum) / longint'(AVG_DEPTH);
        mag = (avg < 0) ? -avg : avg;
        if (mag < longint'(cfg_limit)) begin
            if (hold_count < int'(CNT_TOP)) hold_count++;
        end else begin
            hold_count = 0;
        end
        res.average_speed = avg[SPD_W-1:0];
        res.landed_flag   = (hold_count >= int'(cfg_debounce));
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_report(input t_out got, input t_out want);
        if (got.para_servo_a_cmd !== want.para_servo_a_cmd)
            report_error($sformatf("result %0d servo A: got %0d, want %0d", reports_seen,
                                   got.para_servo_a_cmd, want.para_servo_a_cmd));
        if (got.para_servo_b_cmd !== want.para_servo_b_cmd)
            report_error($sformatf("result %0d servo B: got %0d, want %0d", reports_seen,
                                   got.para_servo_b_cmd, want.para_servo_b_cmd));
        if (got.camera_servo_cmd !== want.camera_servo_cmd)
            report_error($sformatf("result %0d camera: got %0d, want %0d", reports_seen,
                                   got.camera_servo_cmd, want.camera_servo_cmd));
        if (got.average_speed !== want.average_speed)
            report_error($sformatf("result %0d average: got %0d, want %0d", reports_seen,
                                   got.average_speed, want.average_speed));
        if (got.landed_flag !== want.landed_flag)
            report_error($sformatf("result %0d landed: got %0b, want %0b", reports_seen,
                                   got.landed_flag, want.landed_flag));
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued ticks, predict each one on its transfer edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_reports.push_back(predict_landing(i_data));
            end
            // Hold a stalled tick; otherwise load the next one or idle
            if (!i_valid || o_ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_data  <= pending_ticks.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare every result transfer with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_reports.size() == 0) begin
                report_error($sformatf("result %0d arrived with nothing expected",
                                       reports_seen));
            end else begin
                check_report(o_data, expected_reports.pop_front());
            end
            if (o_data.landed_flag === 1'b1) landed_seen++;
            reports_seen++;
        end
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_tick(input logic enter, input logic [TIME_W-1:0] now,
                             input logic signed [ALT_W-1:0] alt, input logic [DT_W-1:0] dt);
        t_in tick;
        tick.enter_state = enter;
        tick.now_ms      = now;
        tick.altitude_cm = alt;
        tick.delta_ms    = dt;
        pending_ticks.push_back(tick);
        ticks_issued++;
        if (dt == '0) zero_dt_ticks++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        track_reg(idx, value);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // Wait until every issued tick has produced its result, then let it settle
    task automatic wait_results();
        int guard;
        guard = 0;
        while (reports_seen < ticks_issued && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Begin a new flight segment on an entry tick
    task automatic start_flight();
        fl_time = $urandom();
        fl_alt  = $urandom_range(0, 300000);
        push_tick(1'b1, fl_time, fl_alt[ALT_W-1:0], DT_W'($urandom_range(10, 100)));
    endtask

    // One loop tick: mostly a plausible descent or hover, sometimes raw noise.
    // Hover mode never breaks the sequence so the debounce count can run long.
    task automatic flight_tick(input bit hover_only);
        logic [31:0]     raw;
        logic [DT_W-1:0] dt;
        int              step;
        if (!hover_only && $urandom_range(0, 99) < 20) begin
            raw = $urandom();
            dt  = ($urandom_range(0, 9) == 0) ? '0 : DT_W'($urandom_range(0, 65535));
            push_tick(1'($urandom_range(0, 1)), $urandom(), raw[ALT_W-1:0], dt);
        end else begin
            if (hover_only) begin
                dt = DT_W'($urandom_range(10, 200));
            end else begin
                dt = ($urandom_range(0, 19) == 0) ? '0 : DT_W'($urandom_range(1, 300));
            end
            if (hover_only || $urandom_range(0, 1) == 1) begin
                step = $urandom_range(0, 40) - 20;
            end else begin
                step = -int'($urandom_range(0, 500));
            end
            fl_time = fl_time + dt;
            fl_alt  = fl_alt + step;
            push_tick(1'($urandom_range(0, 29) == 0), fl_time, fl_alt[ALT_W-1:0], dt);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [TIME_W-1:0] wrap_start;

        reset_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed ticks at the reset register values
        set_idling(0, 0);
        // First tick measures against a zero previous altitude
        push_tick(1'b1, 32'd1000, 24'sd500, 16'd20);
        // Zero interval: flat gives full positive speed, falling full negative
        push_tick(1'b0, 32'd1020, 24'sd500, 16'd0);
        push_tick(1'b0, 32'd1020, 24'sd400, 16'd0);
        // Altitude extremes over a 1 ms interval clip the speed both ways
        push_tick(1'b0, 32'd1021, ALT_TOP, 16'd1);
        push_tick(1'b0, 32'd1022, ALT_BOTTOM, 16'd1);
        push_tick(1'b0, 32'd1023, ALT_TOP, DT_TOP);
        push_tick(1'b0, 32'd1024, ALT_BOTTOM, DT_TOP);
        // Entry just below the time wrap; elapsed time must wrap cleanly
        wrap_start = 32'hFFFF_FF00;
        push_tick(1'b1, wrap_start, 24'sd0, 16'd100);
        push_tick(1'b0, 32'h0000_0A00, 24'sd0, 16'd50);
        push_tick(1'b0, wrap_start + WIND_TIME_RST - 1, 24'sd0, 16'd100);
        push_tick(1'b0, wrap_start + WIND_TIME_RST, 24'sd0, 16'd100);
        push_tick(1'b0, wrap_start + WIND_TIME_RST + 1, 24'sd0, 16'd100);
        // Hold altitude so the ring flushes and the average settles near zero
        for (int k = 0; k < 11; k++) begin
            push_tick(1'b0, 32'd5000 + 100 * k, -24'sd3, 16'd100);
        end
        push_tick(1'b1, 32'd0, -24'sd1, DT_TOP);
        wait_results();

        // Low extremes; writes to the unused index are dropped
        write_reg(CFG_WIND_TIME, '0);
        write_reg(CFG_SPEED_LIMIT, '0);
        write_reg(CFG_SERVO_A, 16'd255);
        write_reg(CFG_SERVO_B, 16'd0);
        write_reg(CFG_SERVO_C, 16'd255);
        write_reg(CFG_CAMERA, 16'd255);
        write_reg(CFG_DEBOUNCE, '0);
        write_reg(CFG_NO_REG, 16'hFFFF);
        settings_used++;
        set_idling(75, 0);
        start_flight();
        for (int k = 0; k < 40; k++) flight_tick(1'b0);
        wait_results();

        // High extremes; a long hover drives the debounce count into saturation
        write_reg(CFG_WIND_TIME, 16'hFFFF);
        write_reg(CFG_SPEED_LIMIT, 16'hFFFF);
        write_reg(CFG_SERVO_A, 16'd0);
        write_reg(CFG_SERVO_B, 16'd255);
        write_reg(CFG_SERVO_C, 16'd0);
        write_reg(CFG_CAMERA, 16'd0);
        write_reg(CFG_DEBOUNCE, 16'd255);
        settings_used++;
        set_idling(0, 0);
        start_flight();
        for (int k = 0; k < 280; k++) flight_tick(1'b1);
        wait_results();

        // Mid-range settings with a single-tick debounce
        write_reg(CFG_WIND_TIME, CFG_W'($urandom_range(100, 2000)));
        write_reg(CFG_SPEED_LIMIT, CFG_W'($urandom_range(50, 3000)));
        write_reg(CFG_SERVO_A, CFG_W'($urandom_range(0, 255)));
        write_reg(CFG_SERVO_B, CFG_W'($urandom_range(0, 255)));
        write_reg(CFG_SERVO_C, CFG_W'($urandom_range(0, 255)));
        write_reg(CFG_CAMERA, CFG_W'($urandom_range(0, 255)));
        write_reg(CFG_DEBOUNCE, 16'd1);
        settings_used++;
        set_idling(0, 75);
        start_flight();
        for (int k = 0; k < 50; k++) flight_tick(1'b0);
        wait_results();

        // Random settings, both channels idling
        write_reg(CFG_WIND_TIME, CFG_W'($urandom_range(0, 65535)));
        write_reg(CFG_SPEED_LIMIT, CFG_W'($urandom_range(200, 5000)));
        write_reg(CFG_SERVO_A, CFG_W'($urandom_range(0, 255)));
        write_reg(CFG_SERVO_B, CFG_W'($urandom_range(0, 255)));
        write_reg(CFG_SERVO_C, CFG_W'($urandom_range(0, 255)));
        write_reg(CFG_CAMERA, CFG_W'($urandom_range(0, 255)));
        write_reg(CFG_DEBOUNCE, CFG_W'($urandom_range(2, 12)));
        settings_used++;
        set_idling(29, 29);
        start_flight();
        for (int k = 0; k < 50; k++) flight_tick(1'b0);
        wait_results();

        // Anything still expected never came out
        if (expected_reports.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_reports.size()));
        end

        $display("Checked %0d results from %0d ticks over %0d register settings.",
                 reports_seen, ticks_issued, settings_used);
        $display("Zero-interval ticks: %0d, results with landed raised: %0d, mismatches: %0d.",
                 zero_dt_ticks, landed_seen, error_count);
        if (error_count == 0) begin
            $display("landing_detector_velocity_average_unit regression: pass");
        end else begin
            $display("landing_detector_velocity_average_unit regression: fail");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5000000;
        $display("Timeout: results still outstanding.");
        $display("landing_detector_velocity_average_unit regression: fail");
        $finish;
    end

endmodule
